>>> src/rmsg_pkg.sv
// ---------------------------------------------------------------------------
// rmsg_pkg
// Shared types and constants of the rms noise gate: field widths, register
// offsets, command codes and the item and configuration records.
// ---------------------------------------------------------------------------
package rmsg_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SQ_W        = 31;   // 32768^2 needs 31 bits
    localparam int SUM_W       = 40;
    localparam int TH_W        = 31;
    localparam int HOLD_W      = 16;
    localparam int SC_W        = 11;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_TUSER_W = 2;

    localparam int DEF_MAX_BLOCK_SAMPLES = 1024;

    localparam logic [SUM_W-1:0]  SUM_MAX   = '1;
    localparam logic [HOLD_W-1:0] QUIET_MAX = '1;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_GATE_ENABLE = 2'd0;
    localparam reg_idx_t REG_THRESHOLD   = 2'd1;
    localparam reg_idx_t REG_HOLD        = 2'd2;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_TICK   = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t            cmd;
        logic [SQ_W-1:0] sq;
        logic            last;
    } sq_item_t;

    typedef struct packed {
        logic              gate_enable;
        logic [TH_W-1:0]   threshold;
        logic [HOLD_W-1:0] hold;
    } gate_cfg_t;

endpackage

>>> src/rmsg_cfg_regs.sv
// ---------------------------------------------------------------------------
// rmsg_cfg_regs
// Configuration registers behind a simple apb port: gate enable, power
// threshold and hold time.
// ---------------------------------------------------------------------------
module rmsg_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rmsg_pkg::ADDR_W-1:0] paddr,
    input  logic [rmsg_pkg::DATA_W-1:0] pwdata,
    output logic [rmsg_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output rmsg_pkg::gate_cfg_t        cfg
);
    import rmsg_pkg::*;

    logic              enable_reg;
    logic [TH_W-1:0]   threshold_reg;
    logic [HOLD_W-1:0] hold_reg;
    reg_idx_t          idx;
    logic              wr;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            threshold_reg <= '0;
            hold_reg      <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_GATE_ENABLE: enable_reg    <= pwdata[0];
                REG_THRESHOLD:   threshold_reg <= pwdata[TH_W-1:0];
                REG_HOLD:        hold_reg      <= pwdata[HOLD_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_GATE_ENABLE: prdata = DATA_W'(enable_reg);
            REG_THRESHOLD:   prdata = DATA_W'(threshold_reg);
            REG_HOLD:        prdata = DATA_W'(hold_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.gate_enable = enable_reg;
    assign cfg.threshold   = threshold_reg;
    assign cfg.hold        = hold_reg;

endmodule

>>> src/rmsg_sq_stage.sv
// ---------------------------------------------------------------------------
// rmsg_sq_stage
// Input register: takes one item per cycle while the output side is ready,
// and registers the squared sample magnitude with the command and end-of-block flag.
// ---------------------------------------------------------------------------
module rmsg_sq_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rmsg_pkg::cmd_t                in_cmd,
    input  logic [rmsg_pkg::SAMPLE_W-1:0] in_sample,
    input  logic                          in_last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output rmsg_pkg::sq_item_t            out_item
);
    import rmsg_pkg::*;

    logic                valid_reg;
    sq_item_t            item_reg;
    sq_item_t            item_next;
    logic [SAMPLE_W:0]   mag_wide;
    logic [SAMPLE_W-1:0] mag;
    logic [2*SAMPLE_W-1:0] sq_full;

    // magnitude of the two's complement sample, -32768 gives 32768
    assign mag_wide = in_sample[SAMPLE_W-1]
                    ? ((SAMPLE_W+1)'(0) - {1'b1, in_sample})
                    : {1'b0, in_sample};
    assign mag      = mag_wide[SAMPLE_W-1:0];
    assign sq_full  = (2*SAMPLE_W)'(mag) * (2*SAMPLE_W)'(mag);

    always_comb
    begin
        item_next.cmd  = in_cmd;
        item_next.sq   = sq_full[SQ_W-1:0];
        item_next.last = in_last;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

>>> src/rmsg_gate_core.sv
// ---------------------------------------------------------------------------
// rmsg_gate_core
// Block accumulator and gate decision: sums squares and counts samples,
// decides loud or quiet at the end of a block, keeps the quiet timer and
// holds the result in an output register.
// ---------------------------------------------------------------------------
module rmsg_gate_core #(
    parameter int MAX_BLOCK_SAMPLES = rmsg_pkg::DEF_MAX_BLOCK_SAMPLES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  rmsg_pkg::sq_item_t         item,
    input  rmsg_pkg::gate_cfg_t        cfg,
    output logic                       res_valid,
    input  logic                       res_ready,
    output logic                       res_open,
    output logic                       res_silent,
    output logic [rmsg_pkg::SUM_W-1:0] res_sum,
    output logic [rmsg_pkg::SC_W-1:0]  res_count
);
    import rmsg_pkg::*;

    localparam int CNT_W  = $clog2(MAX_BLOCK_SAMPLES + 1);
    localparam int PROD_W = CNT_W + TH_W;
    localparam int CMP_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCK_SAMPLES);

    logic [SUM_W-1:0]  acc_reg,   acc_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic              open_reg,  open_next;
    logic [HOLD_W-1:0] quiet_reg, quiet_next;

    logic              out_valid_reg,  out_valid_next;
    logic              out_open_reg,   out_open_next;
    logic              out_silent_reg, out_silent_next;
    logic [SUM_W-1:0]  out_sum_reg,    out_sum_next;
    logic [SC_W-1:0]   out_cnt_reg,    out_cnt_next;

    logic              counting;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  acc_new;
    logic [CNT_W-1:0]  cnt_new;
    logic [PROD_W-1:0] prod;
    logic              loud;
    logic              ends_block;
    logic              out_free;
    logic              fire;
    logic              dec_open;
    logic              dec_silent;
    logic [HOLD_W-1:0] dec_quiet;
    logic [CNT_W+SC_W-1:0] cnt_ext;

    // samples past the block limit are dropped from sum and count
    assign counting = cnt_reg < CNT_MAX;
    assign sum_wide = {1'b0, acc_reg} + (SUM_W+1)'(item.sq);
    assign acc_new  = !counting ? acc_reg : (sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0]);
    assign cnt_new  = counting ? cnt_reg + CNT_W'(1) : cnt_reg;

    // mean-square test without a divide: sum >= count * threshold
    assign prod = PROD_W'(cnt_new) * PROD_W'(cfg.threshold);
    assign loud = CMP_W'(acc_new) >= CMP_W'(prod);

    assign ends_block = (item.cmd == CMD_SAMPLE) && item.last;
    assign out_free   = !out_valid_reg || res_ready;
    assign item_ready = !ends_block || out_free;
    assign fire       = item_valid && item_ready;

    always_comb
    begin
        dec_quiet = quiet_reg;
        if (cfg.gate_enable)
        begin
            priority if (loud)
            begin
                dec_open  = 1'b1;
                dec_quiet = '0;
            end
            else if (open_reg && (quiet_reg >= cfg.hold))
            begin
                dec_open = 1'b0;
            end
            else
            begin
                dec_open = open_reg;
            end
            dec_silent = !dec_open;
        end
        else
        begin
            dec_open   = 1'b1;
            dec_silent = 1'b0;
        end
    end

    assign cnt_ext = (CNT_W+SC_W)'(cnt_new);

    always_comb
    begin
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        open_next       = open_reg;
        quiet_next      = quiet_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        out_open_next   = out_open_reg;
        out_silent_next = out_silent_reg;
        out_sum_next    = out_sum_reg;
        out_cnt_next    = out_cnt_reg;
        if (fire)
        begin
            unique case (item.cmd)
                CMD_TICK:
                begin
                    if (quiet_reg != QUIET_MAX)
                    begin
                        quiet_next = quiet_reg + HOLD_W'(1);
                    end
                end
                CMD_SAMPLE:
                begin
                    acc_next = acc_new;
                    cnt_next = cnt_new;
                    if (item.last)
                    begin
                        open_next       = dec_open;
                        quiet_next      = dec_quiet;
                        acc_next        = '0;
                        cnt_next        = '0;
                        out_valid_next  = 1'b1;
                        out_open_next   = dec_open;
                        out_silent_next = dec_silent;
                        out_sum_next    = acc_new;
                        out_cnt_next    = cnt_ext[SC_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            open_reg      <= 1'b0;
            quiet_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            open_reg      <= open_next;
            quiet_reg     <= quiet_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_open_reg   <= out_open_next;
        out_silent_reg <= out_silent_next;
        out_sum_reg    <= out_sum_next;
        out_cnt_reg    <= out_cnt_next;
    end

    assign res_valid  = out_valid_reg;
    assign res_open   = out_open_reg;
    assign res_silent = out_silent_reg;
    assign res_sum    = out_sum_reg;
    assign res_count  = out_cnt_reg;

endmodule

>>> src/block_rms_noise_gate.sv
// ---------------------------------------------------------------------------
// block_rms_noise_gate
// Rms noise gate with hold: per-block power test and gate state for a
// stream of signed 16-bit samples and millisecond ticks.
// ---------------------------------------------------------------------------
// One item is taken per clock while s_tready is high. A sample that ends a
// block gives one result: the input register holds the squared sample, then
// the output register takes the block decision; ticks and other samples give
// none. The per-cycle path is the square in the input stage, and in the
// second stage the 40-bit saturating add feeding the count * threshold
// compare. s_tready drops only while an end-of-block sample waits on a full
// output register. The user is to write configuration only while the stream
// is idle; the block itself does not enforce it.
// ---------------------------------------------------------------------------
module block_rms_noise_gate #(
    parameter int MAX_BLOCK_SAMPLES = rmsg_pkg::DEF_MAX_BLOCK_SAMPLES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rmsg_pkg::IN_TDATA_W-1:0]  s_tdata,   // [15:0] sample
    input  logic                            s_tuser,   // [0] cmd
    input  logic                            s_tlast,   // block_last
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rmsg_pkg::OUT_TDATA_W-1:0] m_tdata,   // [39:0] sum_squares, [50:40] block count
    output logic [rmsg_pkg::OUT_TUSER_W-1:0] m_tuser,   // [0] open, [1] silent
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rmsg_pkg::ADDR_W-1:0]      paddr,
    input  logic [rmsg_pkg::DATA_W-1:0]      pwdata,
    output logic [rmsg_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import rmsg_pkg::*;

    gate_cfg_t         cfg;
    sq_item_t          sq_item;
    logic              sq_valid;
    logic              sq_ready;
    cmd_t              in_cmd;
    logic              res_open;
    logic              res_silent;
    logic [SUM_W-1:0]  res_sum;
    logic [SC_W-1:0]   res_count;

    assign in_cmd = s_tuser ? CMD_TICK : CMD_SAMPLE;

    rmsg_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rmsg_sq_stage u_sq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (in_cmd),
        .in_sample (s_tdata[SAMPLE_W-1:0]),
        .in_last   (s_tlast),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_item  (sq_item)
    );

    rmsg_gate_core #(
        .MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (sq_valid),
        .item_ready (sq_ready),
        .item       (sq_item),
        .cfg        (cfg),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_open   (res_open),
        .res_silent (res_silent),
        .res_sum    (res_sum),
        .res_count  (res_count)
    );

    assign m_tdata = OUT_TDATA_W'({res_count, res_sum});
    assign m_tuser = {res_silent, res_open};

endmodule

>>> sim/block_rms_noise_gate_tb.sv
// ---------------------------------------------------------------------------
// block_rms_noise_gate_tb
// Self-checking bench for the rms noise gate. A directed table covers the
// sample extremes, ticks, the threshold edge and the gate modes. Random
// blocks then run under a series of gate settings with random idling on
// both stream sides in all phases but one. Every block result is checked
// against a typed-in result or a local prediction of the gate, sum and count.
// ---------------------------------------------------------------------------
module block_rms_noise_gate_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rmsg_pkg::*;

    localparam reg_idx_t REG_UNUSED  = 2'd3;
    localparam int       MAX_SAMPLES = DEF_MAX_BLOCK_SAMPLES;
    localparam int       STALL_LIMIT = 2000;
    localparam int       PHASE_ITEMS = 112;
    localparam int       NUM_PHASES  = 8;

    typedef struct packed {
        logic              open_flag;
        logic              silent;
        logic [SUM_W-1:0]  sum;
        logic [SC_W-1:0]   count;
    } gate_result_t;

    typedef enum logic [1:0] {ROW_ITEM, ROW_KNOWN, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t    kind;
        cmd_t         cmd;
        logic [15:0]  smp;
        logic         lst;
        gate_result_t known;
        reg_idx_t     idx;
        logic [31:0]  val;
    } stim_row_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;    // [15:0] sample
    logic                   s_tuser  = 1'b0;  // [0] cmd
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // [39:0] sum_squares, [50:40] block count
    logic [OUT_TUSER_W-1:0] m_tuser;          // [0] open, [1] silent
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [ADDR_W-1:0]      paddr    = '0;
    logic [DATA_W-1:0]      pwdata   = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    // gate prediction state and register copy
    logic              cfg_enable    = 1'b0;
    logic [TH_W-1:0]   cfg_threshold = '0;
    logic [HOLD_W-1:0] cfg_hold      = '0;
    longint unsigned   blk_power     = 0;
    int                blk_samples   = 0;
    logic              gate_state    = 1'b0;
    logic [HOLD_W-1:0] quiet_timer   = '0;

    gate_result_t gate_results_due[$];
    stim_row_t    dir_rows[$];

    bit no_idle      = 1'b0;
    int errors       = 0;
    int items_sent   = 0;
    int ticks_sent   = 0;
    int blocks_seen  = 0;
    int muted_seen   = 0;
    int reg_writes   = 0;
    int stall_cycles = 0;

    block_rms_noise_gate i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // returns 1 when the item ends a block, with the block's result in r
    function automatic bit gate_decision(input cmd_t c, input logic [15:0] smp,
                                         input logic lst, output gate_result_t r);
        int              s;
        longint unsigned sq;
        longint unsigned floor_power;
        bit              loud;
        r = '0;
        if (c == CMD_TICK)
        begin
            if (quiet_timer != QUIET_MAX)
                quiet_timer++;
            return 1'b0;
        end
        // samples past the block limit are dropped from count and sum
        if (blk_samples < MAX_SAMPLES)
        begin
            s = $signed(smp);
            sq = s * s;
            blk_samples++;
            if (blk_power + sq > SUM_MAX)
                blk_power = SUM_MAX;
            else
                blk_power = blk_power + sq;
        end
        if (!lst)
            return 1'b0;
        if (cfg_enable)
        begin
            floor_power = blk_samples;
            floor_power = floor_power * cfg_threshold;
            loud = blk_power >= floor_power;
            if (loud)
            begin
                gate_state = 1'b1;
                quiet_timer = '0;
            end
            else if (gate_state && quiet_timer >= cfg_hold)
                gate_state = 1'b0;
            r.silent = !gate_state;
        end
        else
        begin
            gate_state = 1'b1;
            r.silent = 1'b0;
        end
        r.open_flag = gate_state;
        r.sum = SUM_W'(blk_power);
        r.count = SC_W'(blk_samples);
        blk_power = 0;
        blk_samples = 0;
        return 1'b1;
    endfunction

    function automatic void add_item(input cmd_t c, input logic [15:0] smp, input logic lst);
        stim_row_t row;
        row.kind = ROW_ITEM;
        row.cmd = c;
        row.smp = smp;
        row.lst = lst;
        row.known = '0;
        row.idx = REG_UNUSED;
        row.val = '0;
        dir_rows.push_back(row);
    endfunction

    // one-sample block, or the last sample of a block, with its result typed in
    function automatic void add_known(input logic [15:0] smp, input logic gate,
                                      input logic sil, input logic [SUM_W-1:0] sum,
                                      input logic [SC_W-1:0] cnt);
        stim_row_t row;
        row.kind = ROW_KNOWN;
        row.cmd = CMD_SAMPLE;
        row.smp = smp;
        row.lst = 1'b1;
        row.known = '{open_flag: gate, silent: sil, sum: sum, count: cnt};
        row.idx = REG_UNUSED;
        row.val = '0;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input reg_idx_t idx, input logic [31:0] val);
        stim_row_t row;
        row.kind = ROW_CFG;
        row.cmd = CMD_SAMPLE;
        row.smp = '0;
        row.lst = 1'b0;
        row.known = '0;
        row.idx = idx;
        row.val = val;
        dir_rows.push_back(row);
    endfunction

    task automatic send_item(input cmd_t c, input logic [15:0] smp, input logic lst,
                             input bit typed, input gate_result_t known);
        gate_result_t r;
        while (!no_idle && $urandom_range(0, 99) < 30)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= c;
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (c == CMD_TICK)
            ticks_sent++;
        if (gate_decision(c, smp, lst, r))
            gate_results_due.push_back(typed ? known : r);
    endtask

    task automatic send_plain(input cmd_t c, input logic [15:0] smp, input logic lst);
        send_item(c, smp, lst, 1'b0, '0);
    endtask

    task automatic send_tick();
        send_plain(CMD_TICK, 16'($urandom), 1'($urandom));
    endtask

    task automatic send_block(input int len, input int shift);
        logic [15:0] raw;
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 99) < 15)
                send_tick();
            raw = $urandom;
            if ($urandom_range(0, 19) == 0)
                raw = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            send_plain(CMD_SAMPLE, 16'($signed(raw) >>> shift), k == len - 1);
        end
    endtask

    // stream quiet and every block result back before touching a register
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (gate_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        // bus idle between transfers
        @(posedge clk);
        reg_writes++;
        unique case (idx)
            REG_GATE_ENABLE: cfg_enable = val[0];
            REG_THRESHOLD:   cfg_threshold = val[TH_W-1:0];
            REG_HOLD:        cfg_hold = val[HOLD_W-1:0];
            default:         ;
        endcase
    endtask

    // result checker and output-side back-pressure
    initial
    begin
        gate_result_t want;
        gate_result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.open_flag = m_tuser[0];
                got.silent = m_tuser[1];
                got.sum = m_tdata[SUM_W-1:0];
                got.count = m_tdata[SUM_W+SC_W-1:SUM_W];
                blocks_seen++;
                if (got.silent)
                    muted_seen++;
                if (gate_results_due.size() == 0)
                begin
                    $display("%0t: unexpected result gate %b silent %b sum %h count %0d",
                             $time, got.open_flag, got.silent, got.sum, got.count);
                    errors++;
                end
                else
                begin
                    want = gate_results_due.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected gate %b silent %b sum %h count %0d",
                                 $time, want.open_flag, want.silent, want.sum, want.count);
                        $display("%0t:          actual   gate %b silent %b sum %h count %0d",
                                 $time, got.open_flag, got.silent, got.sum, got.count);
                        errors++;
                    end
                end
            end
            m_tready <= no_idle || ($urandom_range(0, 99) >= 30);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("block_rms_noise_gate_tb: FAIL");
        $finish;
    end

    initial
    begin
        int          start;
        logic        en;
        logic [31:0] thr;
        logic [31:0] hold;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // gating off after reset: always open, never muted
        add_known(16'h0000, 1'b1, 1'b0, 40'h0, 11'd1);
        add_known(16'h8000, 1'b1, 1'b0, 40'h40000000, 11'd1);
        add_known(16'h7FFF, 1'b1, 1'b0, 40'h3FFF0001, 11'd1);
        add_item(CMD_SAMPLE, 16'hFFFF, 1'b0);
        add_known(16'h0001, 1'b1, 1'b0, 40'h2, 11'd2);
        // tick with tlast set ends nothing
        add_item(CMD_TICK, 16'hFFFF, 1'b1);
        add_cfg(REG_UNUSED, 32'hFFFF_FFFF);
        add_known(16'h8000, 1'b1, 1'b0, 40'h40000000, 11'd1);
        add_cfg(REG_THRESHOLD, 32'h0000_0100);
        add_cfg(REG_HOLD, 32'd2);
        add_cfg(REG_GATE_ENABLE, 32'd1);
        // quiet before the hold runs out, then close once it has
        add_item(CMD_SAMPLE, 16'h0001, 1'b0);
        add_item(CMD_SAMPLE, 16'h0001, 1'b1);
        add_item(CMD_TICK, 16'h0000, 1'b0);
        add_item(CMD_TICK, 16'h1234, 1'b0);
        add_item(CMD_SAMPLE, 16'h0003, 1'b1);
        // exactly at threshold counts as loud
        add_item(CMD_SAMPLE, 16'hFFF0, 1'b1);
        add_item(CMD_SAMPLE, 16'h000F, 1'b1);
        add_cfg(REG_THRESHOLD, 32'h0000_0000);
        add_item(CMD_SAMPLE, 16'h0000, 1'b1);
        // top threshold bit is dropped, full-scale block is quiet and closes at once
        add_cfg(REG_THRESHOLD, 32'hFFFF_FFFF);
        add_cfg(REG_HOLD, 32'd0);
        add_item(CMD_SAMPLE, 16'h8000, 1'b1);
        add_cfg(REG_GATE_ENABLE, 32'hFFFF_FFFE);
        add_item(CMD_SAMPLE, 16'h1234, 1'b1);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                wait_idle();
                reg_write(dir_rows[i].idx, dir_rows[i].val);
            end
            else
                send_item(dir_rows[i].cmd, dir_rows[i].smp, dir_rows[i].lst,
                          dir_rows[i].kind == ROW_KNOWN, dir_rows[i].known);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            unique case (p)
                0:
                begin
                    en = 1'b1;
                    thr = 32'd0;
                    hold = 32'd0;
                end
                1:
                begin
                    en = 1'b1;
                    thr = 32'h7FFF_FFFF;
                    hold = 32'hFFFF;
                end
                2:
                begin
                    en = 1'b1;
                    thr = 32'h4000_0000;
                    hold = $urandom_range(0, 24);
                end
                default:
                begin
                    en = ($urandom_range(0, 4) != 0);
                    thr = $urandom & ((32'h1 << $urandom_range(0, 30)) - 1);
                    hold = $urandom_range(0, 24);
                end
            endcase
            reg_write(REG_GATE_ENABLE, {31'd0, en});
            reg_write(REG_THRESHOLD, thr);
            reg_write(REG_HOLD, hold);
            no_idle = (p == 4);

            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(1, 30)) send_tick();
                send_block($urandom_range(1, 12), $urandom_range(0, 15));
            end
        end
        no_idle = 1'b0;

        wait_idle();
        repeat (8) @(posedge clk);
        $display("%0d items sent (%0d ticks), %0d block results checked, %0d register writes",
                 items_sent, ticks_sent, blocks_seen, reg_writes);
        $display("%0d muted blocks, %0d errors", muted_seen, errors);
        if (errors == 0)
            $display("block_rms_noise_gate_tb: PASS");
        else
            $display("block_rms_noise_gate_tb: FAIL");
        $finish;
    end

endmodule

>>> block_rms_noise_gate.f
src/rmsg_pkg.sv
src/rmsg_cfg_regs.sv
src/rmsg_sq_stage.sv
src/rmsg_gate_core.sv
src/block_rms_noise_gate.sv
sim/block_rms_noise_gate_tb.sv
